/* src/p2u_pkg.sv */
// shared types, codes and lookup tables of the petscii to utf-8 terminal unit
package p2u_pkg;

  // sequence templates run by the back end after the optional glyph
  localparam logic [3:0] TM_NONE   = 4'd0;
  localparam logic [3:0] TM_REVOFF = 4'd1;
  localparam logic [3:0] TM_LINE   = 4'd2;
  localparam logic [3:0] TM_FORE   = 4'd3;
  localparam logic [3:0] TM_CLR    = 4'd4;
  localparam logic [3:0] TM_DOWN   = 4'd5;
  localparam logic [3:0] TM_REV    = 4'd6;
  localparam logic [3:0] TM_HOME   = 4'd7;
  localparam logic [3:0] TM_DEL    = 4'd8;
  localparam logic [3:0] TM_ESC    = 4'd9;
  localparam logic [3:0] TM_RIGHT  = 4'd10;
  localparam logic [3:0] TM_UP     = 4'd11;
  localparam logic [3:0] TM_INS    = 4'd12;
  localparam logic [3:0] TM_LEFT   = 4'd13;
  localparam logic [3:0] TM_HEX    = 4'd14;

  // token kinds inside a template
  localparam logic [2:0] TK_END  = 3'd0;
  localparam logic [2:0] TK_BYTE = 3'd1;
  localparam logic [2:0] TK_DECF = 3'd2;
  localparam logic [2:0] TK_DECB = 3'd3;
  localparam logic [2:0] TK_HEXH = 3'd4;
  localparam logic [2:0] TK_HEXL = 3'd5;

  localparam logic [7:0] ASC_ESC = 8'h1B;
  localparam logic [6:0] FORE_RESET = 7'd97;
  localparam logic [6:0] BACK_RESET = 7'd44;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef logic [10:0] tok_t;

  typedef struct packed {
    logic        glyph_en;
    logic [20:0] cp;
    logic [3:0]  tmpl;
    logic [6:0]  fore;
    logic [6:0]  back;
    logic [7:0]  code;
  } cmd_t;

  function automatic tok_t mk_tok(logic [2:0] kind, logic [7:0] b);
    return {kind, b};
  endfunction

  function automatic tok_t tmpl_tok(logic [3:0] tm, logic [3:0] idx);
    tok_t t;
    logic [3:0] r;
    t = mk_tok(TK_END, 8'h00);
    // line end is a newline followed by reverse off
    r = (tm == TM_LINE) ? idx - 4'd1 : idx;
    case (tm)
      TM_REVOFF, TM_LINE: begin
        if (tm == TM_LINE && idx == 4'd0) begin
          t = mk_tok(TK_BYTE, 8'h0A);
        end else begin
          case (r)
            4'd0: t = mk_tok(TK_BYTE, ASC_ESC);
            4'd1: t = mk_tok(TK_BYTE, "[");
            4'd2: t = mk_tok(TK_BYTE, "0");
            4'd3: t = mk_tok(TK_BYTE, ";");
            4'd4: t = mk_tok(TK_DECB, 8'h00);
            4'd5: t = mk_tok(TK_BYTE, "m");
            4'd6: t = mk_tok(TK_BYTE, ASC_ESC);
            4'd7: t = mk_tok(TK_BYTE, "[");
            4'd8: t = mk_tok(TK_DECF, 8'h00);
            4'd9: t = mk_tok(TK_BYTE, "m");
            default: t = mk_tok(TK_END, 8'h00);
          endcase
        end
      end
      TM_FORE: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd1: t = mk_tok(TK_BYTE, "[");
          4'd2: t = mk_tok(TK_DECF, 8'h00);
          4'd3: t = mk_tok(TK_BYTE, "m");
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      TM_CLR: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd1: t = mk_tok(TK_BYTE, "[");
          4'd2: t = mk_tok(TK_DECB, 8'h00);
          4'd3: t = mk_tok(TK_BYTE, "m");
          4'd4: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd5: t = mk_tok(TK_BYTE, "[");
          4'd6: t = mk_tok(TK_BYTE, "2");
          4'd7: t = mk_tok(TK_BYTE, "J");
          4'd8: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd9: t = mk_tok(TK_BYTE, "[");
          4'd10: t = mk_tok(TK_BYTE, "H");
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      TM_DOWN, TM_HOME, TM_RIGHT, TM_UP, TM_LEFT: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd1: t = mk_tok(TK_BYTE, "[");
          4'd2: begin
            case (tm)
              TM_DOWN:  t = mk_tok(TK_BYTE, "B");
              TM_HOME:  t = mk_tok(TK_BYTE, "H");
              TM_RIGHT: t = mk_tok(TK_BYTE, "C");
              TM_UP:    t = mk_tok(TK_BYTE, "A");
              default:  t = mk_tok(TK_BYTE, "D");
            endcase
          end
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      TM_REV, TM_INS: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd1: t = mk_tok(TK_BYTE, "[");
          4'd2: t = mk_tok(TK_BYTE, (tm == TM_REV) ? "7" : "1");
          4'd3: t = mk_tok(TK_BYTE, (tm == TM_REV) ? "m" : "@");
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      TM_DEL: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, 8'h08);
          4'd1: t = mk_tok(TK_BYTE, ASC_ESC);
          4'd2: t = mk_tok(TK_BYTE, "[");
          4'd3: t = mk_tok(TK_BYTE, "1");
          4'd4: t = mk_tok(TK_BYTE, "P");
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      TM_ESC: begin
        if (idx == 4'd0) t = mk_tok(TK_BYTE, ASC_ESC);
      end
      TM_HEX: begin
        case (idx)
          4'd0: t = mk_tok(TK_BYTE, "\\");
          4'd1: t = mk_tok(TK_BYTE, "x");
          4'd2: t = mk_tok(TK_HEXH, 8'h00);
          4'd3: t = mk_tok(TK_HEXL, 8'h00);
          default: t = mk_tok(TK_END, 8'h00);
        endcase
      end
      default: t = mk_tok(TK_END, 8'h00);
    endcase
    return t;
  endfunction

  // hundreds, tens and ones of a 7-bit value, by reciprocal multiply
  function automatic logic [11:0] dec3(logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  o;
    logic [3:0]  h;
    logic [3:0]  t;
    p = {8'd0, v} * 15'd205;
    q = p[14:11];
    o = v - 7'({3'd0, q} * 7'd10);
    h = (q >= 4'd10) ? 4'd1 : 4'd0;
    t = q - ((q >= 4'd10) ? 4'd10 : 4'd0);
    return {h, t, o[3:0]};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] nbm1,
                                           logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (nbm1)
      2'd0: b = cp[7:0];
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (idx)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  // lookups return {hit, code point}
  function automatic logic [21:0] common_lut(logic [7:0] c);
    logic [21:0] r;
    r = {1'b1, 21'h0};
    case (c)
      8'h5C: r[20:0] = 21'h00A3;
      8'h5E: r[20:0] = 21'h2191;
      8'h5F: r[20:0] = 21'h2190;
      8'h60: r[20:0] = 21'h2500;
      8'h7B: r[20:0] = 21'h253C;
      8'h7C: r[20:0] = 21'h1FB8C;
      8'h7D: r[20:0] = 21'h2502;
      8'hA0: r[20:0] = 21'h00A0;
      8'hA1: r[20:0] = 21'h258C;
      8'hA2: r[20:0] = 21'h2584;
      8'hA3: r[20:0] = 21'h2594;
      8'hA4: r[20:0] = 21'h2581;
      8'hA5: r[20:0] = 21'h258F;
      8'hA6: r[20:0] = 21'h2592;
      8'hA7: r[20:0] = 21'h2595;
      8'hA8: r[20:0] = 21'h1FB8F;
      8'hAA: r[20:0] = 21'h1FB87;
      8'hAB: r[20:0] = 21'h251C;
      8'hAC: r[20:0] = 21'h2597;
      8'hAD: r[20:0] = 21'h2514;
      8'hAE: r[20:0] = 21'h2510;
      8'hAF: r[20:0] = 21'h2582;
      8'hB0: r[20:0] = 21'h250C;
      8'hB1: r[20:0] = 21'h2534;
      8'hB2: r[20:0] = 21'h252C;
      8'hB3: r[20:0] = 21'h2524;
      8'hB4: r[20:0] = 21'h258E;
      8'hB5: r[20:0] = 21'h258D;
      8'hB6: r[20:0] = 21'h1FB88;
      8'hB7: r[20:0] = 21'h1FB82;
      8'hB8: r[20:0] = 21'h1FB83;
      8'hB9: r[20:0] = 21'h2583;
      8'hBB: r[20:0] = 21'h2596;
      8'hBC: r[20:0] = 21'h259D;
      8'hBD: r[20:0] = 21'h2518;
      8'hBE: r[20:0] = 21'h2598;
      8'hBF: r[20:0] = 21'h259A;
      default: r = 22'h0;
    endcase
    return r;
  endfunction

  function automatic logic [21:0] upper_lut(logic [7:0] c);
    logic [21:0] r;
    r = {1'b1, 21'h0};
    case (c)
      8'h61: r[20:0] = 21'h2660;
      8'h62: r[20:0] = 21'h2502;
      8'h63: r[20:0] = 21'h2500;
      8'h64: r[20:0] = 21'h1FB77;
      8'h65: r[20:0] = 21'h1FB76;
      8'h66: r[20:0] = 21'h1FB7A;
      8'h67: r[20:0] = 21'h1FB71;
      8'h68: r[20:0] = 21'h1FB74;
      8'h69: r[20:0] = 21'h256E;
      8'h6A: r[20:0] = 21'h2570;
      8'h6B: r[20:0] = 21'h256F;
      8'h6C: r[20:0] = 21'h1FB7C;
      8'h6D: r[20:0] = 21'h2572;
      8'h6E: r[20:0] = 21'h2571;
      8'h6F: r[20:0] = 21'h1FB7D;
      8'h70: r[20:0] = 21'h1FB7E;
      8'h71: r[20:0] = 21'h25CF;
      8'h72: r[20:0] = 21'h1FB7B;
      8'h73: r[20:0] = 21'h2665;
      8'h74: r[20:0] = 21'h1FB70;
      8'h75: r[20:0] = 21'h256D;
      8'h76: r[20:0] = 21'h2573;
      8'h77: r[20:0] = 21'h25CB;
      8'h78: r[20:0] = 21'h2663;
      8'h79: r[20:0] = 21'h1FB75;
      8'h7A: r[20:0] = 21'h2666;
      8'h7E: r[20:0] = 21'h03C0;
      8'h7F: r[20:0] = 21'h25E5;
      8'hA9: r[20:0] = 21'h25E4;
      8'hBA: r[20:0] = 21'h1FB7F;
      8'hFF: r[20:0] = 21'h03C0;
      default: r = 22'h0;
    endcase
    return r;
  endfunction

  function automatic logic [21:0] lower_lut(logic [7:0] c);
    logic [21:0] r;
    r = {1'b1, 21'h0};
    case (c)
      8'h7E: r[20:0] = 21'h1FB96;
      8'h7F: r[20:0] = 21'h1FB98;
      8'hA9: r[20:0] = 21'h1FB99;
      8'hBA: r[20:0] = 21'h2713;
      8'hFF: r[20:0] = 21'h1FB96;
      default: r = 22'h0;
    endcase
    return r;
  endfunction

  // latin-9 byte to code point; untouched bytes map to themselves
  function automatic logic [20:0] iso_cp(logic [7:0] c);
    logic [20:0] r;
    case (c)
      8'hA4: r = 21'h20AC;
      8'hA6: r = 21'h0160;
      8'hA8: r = 21'h0161;
      8'hB4: r = 21'h017D;
      8'hB8: r = 21'h017E;
      8'hBC: r = 21'h0152;
      8'hBD: r = 21'h0153;
      8'hBE: r = 21'h0178;
      default: r = {13'd0, c};
    endcase
    return r;
  endfunction

endpackage

/* src/p2u_front.sv */
// front end: takes input bytes, tracks terminal state and builds commands
module p2u_front import p2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic       glyph_q;
  logic       iso_q, iso_d;
  logic       lower_q, lower_d;
  logic [6:0] fore_q, fore_d;
  logic [6:0] back_q, back_d;
  logic       emit;
  logic       accept;
  logic [7:0] c;
  logic [7:0] c2;
  logic [7:0] c3;
  logic [21:0] hit_c;
  logic [21:0] hit_u;
  logic [21:0] hit_l;
  logic [11:0] df;
  logic [11:0] db;
  logic [20:0] pcp;

  assign c = in_byte_i;
  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;
  assign push_o = accept && emit;
  assign df = dec3(fore_q);
  assign db = dec3(back_q);

  // graphics remap of the shifted ranges, and letter case swap for the shifted set
  always_comb begin
    c2 = c;
    if (c >= 8'hC0 && c <= 8'hDF) c2 = c - 8'h60;
    else if (c >= 8'hE0 && c <= 8'hFE) c2 = c - 8'h40;
    c3 = c2;
    if (c2 >= "A" && c2 <= "Z") c3 = c2 + 8'h20;
    else if (c2 >= "a" && c2 <= "z") c3 = c2 - 8'h20;
  end

  assign hit_c = common_lut(c2);
  assign hit_u = upper_lut(c2);
  assign hit_l = lower_lut(c2);

  always_comb begin
    if (iso_q) begin
      pcp = (c == 8'h7F) ? 21'h20 : iso_cp(c);
    end else if (hit_c[21]) begin
      pcp = hit_c[20:0];
    end else if (!lower_q) begin
      pcp = hit_u[21] ? hit_u[20:0] : iso_cp(c2);
    end else begin
      pcp = hit_l[21] ? hit_l[20:0] : iso_cp(c3);
    end
  end

  always_comb begin
    emit = 1'b1;
    iso_d = iso_q;
    lower_d = lower_q;
    fore_d = fore_q;
    back_d = back_q;
    cmd_o.glyph_en = 1'b0;
    cmd_o.cp = pcp;
    cmd_o.tmpl = TM_NONE;
    cmd_o.code = c;
    if (c <= 8'h1F || (c >= 8'h80 && c <= 8'h9F)) begin
      cmd_o.tmpl = TM_FORE;
      case (c)
        8'h01: begin
          // swap by last decimal digit
          fore_d = ((db[11:8] == 4'd0 && db[7:4] == 4'd4) ? 7'd30 : 7'd90)
                   + {3'd0, db[3:0]};
          back_d = ((df[11:8] == 4'd0 && df[7:4] == 4'd3) ? 7'd40 : 7'd100)
                   + {3'd0, df[3:0]};
          cmd_o.tmpl = TM_REVOFF;
        end
        8'h05: fore_d = 7'd97;
        8'h0A: begin
          cmd_o.glyph_en = glyph_q; cmd_o.cp = 21'h24B6; cmd_o.tmpl = TM_LINE;
        end
        8'h0D: begin
          cmd_o.glyph_en = glyph_q; cmd_o.cp = 21'h24B9; cmd_o.tmpl = TM_LINE;
        end
        8'h8D: begin
          cmd_o.glyph_en = glyph_q; cmd_o.cp = 21'h24CB; cmd_o.tmpl = TM_LINE;
        end
        8'h92: cmd_o.tmpl = TM_REVOFF;
        8'h0E: begin
          lower_d = 1'b1; emit = 1'b0;
        end
        8'h0F: begin
          iso_d = 1'b1; lower_d = 1'b1; emit = 1'b0;
        end
        8'h8E: begin
          lower_d = 1'b0; emit = 1'b0;
        end
        8'h8F: begin
          iso_d = 1'b0; lower_d = 1'b0; emit = 1'b0;
        end
        8'h11: cmd_o.tmpl = TM_DOWN;
        8'h12: cmd_o.tmpl = TM_REV;
        8'h13: cmd_o.tmpl = TM_HOME;
        8'h14: cmd_o.tmpl = TM_DEL;
        8'h1B: cmd_o.tmpl = TM_ESC;
        8'h1C: fore_d = 7'd31;
        8'h1D: cmd_o.tmpl = TM_RIGHT;
        8'h1E: fore_d = 7'd32;
        8'h1F: fore_d = 7'd34;
        8'h81: fore_d = 7'd33;
        8'h90: fore_d = 7'd30;
        8'h91: cmd_o.tmpl = TM_UP;
        8'h93: cmd_o.tmpl = TM_CLR;
        8'h94: cmd_o.tmpl = TM_INS;
        8'h95: fore_d = 7'd33;
        8'h96: fore_d = 7'd91;
        8'h97: fore_d = 7'd90;
        8'h98: fore_d = 7'd90;
        8'h99: fore_d = 7'd92;
        8'h9A: fore_d = 7'd94;
        8'h9B: fore_d = 7'd37;
        8'h9C: fore_d = 7'd35;
        8'h9D: cmd_o.tmpl = TM_LEFT;
        8'h9E: fore_d = 7'd93;
        8'h9F: fore_d = 7'd36;
        default: cmd_o.tmpl = TM_HEX;
      endcase
    end else begin
      cmd_o.glyph_en = 1'b1;
    end
    cmd_o.fore = fore_d;
    cmd_o.back = back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q <= 1'b0;
      iso_q <= 1'b0;
      lower_q <= 1'b0;
      fore_q <= FORE_RESET;
      back_q <= BACK_RESET;
    end else begin
      if (cfg_we_i) glyph_q <= cfg_data_i;
      if (accept) begin
        iso_q <= iso_d;
        lower_q <= lower_d;
        fore_q <= fore_d;
        back_q <= back_d;
      end
    end
  end

endmodule

/* src/p2u_queue.sv */
// short command queue between front and back end
module p2u_queue import p2u_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign full_o = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* src/p2u_back.sv */
// back end: expands one command into output bytes, one a cycle while the output is not stalled
module p2u_back import p2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic       in_tok_q;
  logic [1:0] gidx_q;
  logic [3:0] tidx_q;
  logic [1:0] didx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q;

  logic       fire;
  logic       tok_phase;
  logic [1:0] nbm1;
  logic       glyph_done;
  tok_t       tok_cur;
  tok_t       tok_nxt;
  tok_t       tok_first;
  logic [6:0] dv;
  logic [11:0] dd;
  logic [1:0] nd;
  logic [1:0] dpos;
  logic       tok_done;
  logic [7:0] byte_c;
  logic       last_c;

  assign fire = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign tok_phase = in_tok_q || !cmd_i.glyph_en;

  assign nbm1 = (cmd_i.cp < 21'h80) ? 2'd0 : (cmd_i.cp < 21'h800) ? 2'd1 :
                (cmd_i.cp < 21'h10000) ? 2'd2 : 2'd3;
  assign glyph_done = (gidx_q == nbm1);

  assign tok_cur = tmpl_tok(cmd_i.tmpl, tidx_q);
  assign tok_nxt = tmpl_tok(cmd_i.tmpl, tidx_q + 4'd1);
  assign tok_first = tmpl_tok(cmd_i.tmpl, 4'd0);

  // decimal colour digits, no leading zeros
  assign dv = (tok_cur[10:8] == TK_DECF) ? cmd_i.fore : cmd_i.back;
  assign dd = dec3(dv);
  assign nd = (dv >= 7'd100) ? 2'd2 : (dv >= 7'd10) ? 2'd1 : 2'd0;
  assign dpos = didx_q + (2'd2 - nd);

  always_comb begin
    tok_done = 1'b1;
    byte_c = tok_cur[7:0];
    if (!tok_phase) begin
      byte_c = utf8_byte(cmd_i.cp, nbm1, gidx_q);
      last_c = glyph_done && (tok_first[10:8] == TK_END);
    end else begin
      case (tok_cur[10:8])
        TK_DECF, TK_DECB: begin
          tok_done = (didx_q == nd);
          case (dpos)
            2'd0: byte_c = 8'h30 + {4'd0, dd[11:8]};
            2'd1: byte_c = 8'h30 + {4'd0, dd[7:4]};
            default: byte_c = 8'h30 + {4'd0, dd[3:0]};
          endcase
        end
        TK_HEXH: byte_c = hex_char(cmd_i.code[7:4]);
        TK_HEXL: byte_c = hex_char(cmd_i.code[3:0]);
        default: byte_c = tok_cur[7:0];
      endcase
      last_c = tok_done && (tok_nxt[10:8] == TK_END);
    end
  end

  assign pop_o = fire && last_c;
  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o = last_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= byte_c;
      last_q <= last_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      in_tok_q <= 1'b0;
      gidx_q <= '0;
      tidx_q <= '0;
      didx_q <= '0;
    end else begin
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (fire) begin
        if (last_c) begin
          in_tok_q <= 1'b0;
          gidx_q <= '0;
          tidx_q <= '0;
          didx_q <= '0;
        end else if (!tok_phase) begin
          if (glyph_done) in_tok_q <= 1'b1;
          else gidx_q <= gidx_q + 2'd1;
        end else if (tok_done) begin
          tidx_q <= tidx_q + 4'd1;
          didx_q <= '0;
        end else begin
          didx_q <= didx_q + 2'd1;
        end
      end
    end
  end

endmodule

/* src/petscii_to_utf8_terminal_unit.sv */
// top level of the petscii to utf-8 terminal unit
// Input channel in_byte_i/in_valid_i/in_ready_o takes one PETSCII byte per
// beat. Output channel out_byte_o/last_o/out_valid_o/out_ready_i gives the
// UTF-8 text and escape sequence bytes for it, one byte per beat, last_o
// set on the final byte of each input byte. Mode and case codes give none.
// cfg_we_i/cfg_data_i set the line-end glyph option at once.
// The front end takes a byte every cycle while its four-entry command queue
// has room and updates the mode, case and colour state on the spot.
// The back end sequencer sends one output byte per cycle while the receiver
// takes them, as many as the input byte produces; plain characters give 1 to 4.
// The first output byte passes through the command queue and then the output register.
// When the receiver stalls the output register holds its beat, the
// sequencer waits, and the queue fills until in_ready_o drops.
// Reset empties the queue and output register and returns to PETSCII mode,
// unshifted, white on blue, glyph option off.
module petscii_to_utf8_terminal_unit import p2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic push, full, pop, q_valid;
  cmd_t cmd_in, cmd_out;

  p2u_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_byte_i, .in_valid_i,
    .in_ready_o, .q_full_i(full), .push_o(push), .cmd_o(cmd_in)
  );

  p2u_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .cmd_o(cmd_out)
  );

  p2u_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(cmd_out), .pop_o(pop),
    .out_byte_o, .last_o, .out_valid_o, .out_ready_i
  );

endmodule

/* bench/petscii_to_utf8_terminal_unit_checker.sv */
// checker for the petscii to utf-8 terminal unit: predicts output beats and compares them
`timescale 1ns / 100ps
module petscii_to_utf8_terminal_unit_checker import p2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic [7:0] out_byte_o,
  input  logic       last_o,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  // control codes with a behavior of their own
  localparam logic [7:0] CC_SWAP     = 8'h01;
  localparam logic [7:0] CC_WHITE    = 8'h05;
  localparam logic [7:0] CC_LF       = 8'h0A;
  localparam logic [7:0] CC_CR       = 8'h0D;
  localparam logic [7:0] CC_LOWER    = 8'h0E;
  localparam logic [7:0] CC_ISO      = 8'h0F;
  localparam logic [7:0] CC_DOWN     = 8'h11;
  localparam logic [7:0] CC_REV_ON   = 8'h12;
  localparam logic [7:0] CC_HOME     = 8'h13;
  localparam logic [7:0] CC_DEL      = 8'h14;
  localparam logic [7:0] CC_ESC      = 8'h1B;
  localparam logic [7:0] CC_RED      = 8'h1C;
  localparam logic [7:0] CC_RIGHT    = 8'h1D;
  localparam logic [7:0] CC_GREEN    = 8'h1E;
  localparam logic [7:0] CC_BLUE     = 8'h1F;
  localparam logic [7:0] CC_ORANGE   = 8'h81;
  localparam logic [7:0] CC_SHIFT_CR = 8'h8D;
  localparam logic [7:0] CC_UPPER    = 8'h8E;
  localparam logic [7:0] CC_PETSCII  = 8'h8F;
  localparam logic [7:0] CC_BLACK    = 8'h90;
  localparam logic [7:0] CC_UP       = 8'h91;
  localparam logic [7:0] CC_REV_OFF  = 8'h92;
  localparam logic [7:0] CC_CLEAR    = 8'h93;
  localparam logic [7:0] CC_INSERT   = 8'h94;
  localparam logic [7:0] CC_BROWN    = 8'h95;
  localparam logic [7:0] CC_PINK     = 8'h96;
  localparam logic [7:0] CC_GREY1    = 8'h97;
  localparam logic [7:0] CC_GREY2    = 8'h98;
  localparam logic [7:0] CC_LGREEN   = 8'h99;
  localparam logic [7:0] CC_LBLUE    = 8'h9A;
  localparam logic [7:0] CC_GREY3    = 8'h9B;
  localparam logic [7:0] CC_PURPLE   = 8'h9C;
  localparam logic [7:0] CC_LEFT     = 8'h9D;
  localparam logic [7:0] CC_YELLOW   = 8'h9E;
  localparam logic [7:0] CC_CYAN     = 8'h9F;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t  text_q[$];
  logic       glyph_on;
  logic       iso_on;
  logic       lower_on;
  logic [6:0] fore;
  logic [6:0] back;

  assign pending_o = text_q.size();

  function automatic int common_glyph(logic [7:0] c);
    case (c)
      8'h5C: return 'h00A3;  8'h5E: return 'h2191;  8'h5F: return 'h2190;
      8'h60: return 'h2500;  8'h7B: return 'h253C;  8'h7C: return 'h1FB8C;
      8'h7D: return 'h2502;  8'hA0: return 'h00A0;  8'hA1: return 'h258C;
      8'hA2: return 'h2584;  8'hA3: return 'h2594;  8'hA4: return 'h2581;
      8'hA5: return 'h258F;  8'hA6: return 'h2592;  8'hA7: return 'h2595;
      8'hA8: return 'h1FB8F; 8'hAA: return 'h1FB87; 8'hAB: return 'h251C;
      8'hAC: return 'h2597;  8'hAD: return 'h2514;  8'hAE: return 'h2510;
      8'hAF: return 'h2582;  8'hB0: return 'h250C;  8'hB1: return 'h2534;
      8'hB2: return 'h252C;  8'hB3: return 'h2524;  8'hB4: return 'h258E;
      8'hB5: return 'h258D;  8'hB6: return 'h1FB88; 8'hB7: return 'h1FB82;
      8'hB8: return 'h1FB83; 8'hB9: return 'h2583;  8'hBB: return 'h2596;
      8'hBC: return 'h259D;  8'hBD: return 'h2518;  8'hBE: return 'h2598;
      8'hBF: return 'h259A;
      default: return 0;
    endcase
  endfunction

  function automatic int upper_glyph(logic [7:0] c);
    case (c)
      8'h61: return 'h2660;  8'h62: return 'h2502;  8'h63: return 'h2500;
      8'h64: return 'h1FB77; 8'h65: return 'h1FB76; 8'h66: return 'h1FB7A;
      8'h67: return 'h1FB71; 8'h68: return 'h1FB74; 8'h69: return 'h256E;
      8'h6A: return 'h2570;  8'h6B: return 'h256F;  8'h6C: return 'h1FB7C;
      8'h6D: return 'h2572;  8'h6E: return 'h2571;  8'h6F: return 'h1FB7D;
      8'h70: return 'h1FB7E; 8'h71: return 'h25CF;  8'h72: return 'h1FB7B;
      8'h73: return 'h2665;  8'h74: return 'h1FB70; 8'h75: return 'h256D;
      8'h76: return 'h2573;  8'h77: return 'h25CB;  8'h78: return 'h2663;
      8'h79: return 'h1FB75; 8'h7A: return 'h2666;  8'h7E: return 'h03C0;
      8'h7F: return 'h25E5;  8'hA9: return 'h25E4;  8'hBA: return 'h1FB7F;
      8'hFF: return 'h03C0;
      default: return 0;
    endcase
  endfunction

  function automatic int lower_glyph(logic [7:0] c);
    case (c)
      8'h7E: return 'h1FB96; 8'h7F: return 'h1FB98; 8'hA9: return 'h1FB99;
      8'hBA: return 'h2713;  8'hFF: return 'h1FB96;
      default: return 0;
    endcase
  endfunction

  function automatic int latin9_glyph(logic [7:0] c);
    case (c)
      8'hA4: return 'h20AC; 8'hA6: return 'h0160; 8'hA8: return 'h0161;
      8'hB4: return 'h017D; 8'hB8: return 'h017E; 8'hBC: return 'h0152;
      8'hBD: return 'h0153; 8'hBE: return 'h0178;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 10) ? 8'(48 + n) : 8'(55 + n);
  endfunction

  task automatic emit(int b);
    out_beat_t e;
    e.data = 8'(b);
    e.last = 1'b0;
    text_q.push_back(e);
  endtask

  task automatic emit_str(string s);
    for (int i = 0; i < s.len(); i++) emit(s[i]);
  endtask

  task automatic emit_dec(int v);
    if (v >= 100) emit(48 + v / 100);
    if (v >= 10) emit(48 + (v / 10) % 10);
    emit(48 + v % 10);
  endtask

  task automatic emit_code_point(int u);
    if (u < 'h80) begin
      emit(u);
    end else if (u < 'h800) begin
      emit('hC0 | (u >> 6));
      emit('h80 | (u & 'h3F));
    end else if (u < 'h10000) begin
      emit('hE0 | (u >> 12));
      emit('h80 | ((u >> 6) & 'h3F));
      emit('h80 | (u & 'h3F));
    end else begin
      emit('hF0 | ((u >> 18) & 7));
      emit('h80 | ((u >> 12) & 'h3F));
      emit('h80 | ((u >> 6) & 'h3F));
      emit('h80 | (u & 'h3F));
    end
  endtask

  task automatic emit_latin9(logic [7:0] c);
    int cp;
    cp = latin9_glyph(c);
    if (cp != 0) begin
      emit_code_point(cp);
    end else if (c < 8'h80) begin
      emit(c);
    end else begin
      emit((c > 8'hBF) ? 'hC3 : 'hC2);
      emit((c & 'h3F) + 'h80);
    end
  endtask

  task automatic set_fore(int v);
    fore = 7'(v);
    emit(ASC_ESC); emit_str("["); emit_dec(fore); emit_str("m");
  endtask

  task automatic emit_rev_off();
    emit(ASC_ESC); emit_str("[0;"); emit_dec(back); emit_str("m");
    emit(ASC_ESC); emit_str("["); emit_dec(fore); emit_str("m");
  endtask

  task automatic emit_line_end(int glyph);
    if (glyph_on) emit_code_point(glyph);
    emit('h0A);
    emit_rev_off();
  endtask

  task automatic predict_control(logic [7:0] c);
    int f, b;
    case (c)
      CC_SWAP: begin
        f = fore;
        b = back;
        fore = 7'(((b / 10 == 4) ? 30 : 90) + b % 10);
        back = 7'(((f / 10 == 3) ? 40 : 100) + f % 10);
        emit_rev_off();
      end
      CC_WHITE:    set_fore(97);
      CC_LF:       emit_line_end('h24B6);
      CC_CR:       emit_line_end('h24B9);
      CC_SHIFT_CR: emit_line_end('h24CB);
      CC_REV_OFF:  emit_rev_off();
      CC_LOWER:    lower_on = 1'b1;
      CC_ISO:      begin iso_on = 1'b1; lower_on = 1'b1; end
      CC_UPPER:    lower_on = 1'b0;
      CC_PETSCII:  begin iso_on = 1'b0; lower_on = 1'b0; end
      CC_DOWN:     begin emit(ASC_ESC); emit_str("[B"); end
      CC_REV_ON:   begin emit(ASC_ESC); emit_str("[7m"); end
      CC_HOME:     begin emit(ASC_ESC); emit_str("[H"); end
      CC_DEL:      begin emit('h08); emit(ASC_ESC); emit_str("[1P"); end
      CC_ESC:      emit(ASC_ESC);
      CC_RED:      set_fore(31);
      CC_RIGHT:    begin emit(ASC_ESC); emit_str("[C"); end
      CC_GREEN:    set_fore(32);
      CC_BLUE:     set_fore(34);
      CC_ORANGE:   set_fore(33);
      CC_BLACK:    set_fore(30);
      CC_UP:       begin emit(ASC_ESC); emit_str("[A"); end
      CC_CLEAR: begin
        emit(ASC_ESC); emit_str("["); emit_dec(back); emit_str("m");
        emit(ASC_ESC); emit_str("[2J"); emit(ASC_ESC); emit_str("[H");
      end
      CC_INSERT:   begin emit(ASC_ESC); emit_str("[1@"); end
      CC_BROWN:    set_fore(33);
      CC_PINK:     set_fore(91);
      CC_GREY1:    set_fore(90);
      CC_GREY2:    set_fore(90);
      CC_LGREEN:   set_fore(92);
      CC_LBLUE:    set_fore(94);
      CC_GREY3:    set_fore(37);
      CC_PURPLE:   set_fore(35);
      CC_LEFT:     begin emit(ASC_ESC); emit_str("[D"); end
      CC_YELLOW:   set_fore(93);
      CC_CYAN:     set_fore(36);
      default: begin
        emit_str("\\x"); emit(hex_digit(c[7:4])); emit(hex_digit(c[3:0]));
      end
    endcase
  endtask

  task automatic predict_printable(logic [7:0] c);
    int cp;
    if (iso_on) begin
      if (c == 8'h7F) emit_str(" ");
      else emit_latin9(c);
      return;
    end
    if (c >= 8'hC0 && c <= 8'hDF) c = c - 8'h60;
    else if (c >= 8'hE0 && c <= 8'hFE) c = c - 8'h40;
    cp = common_glyph(c);
    if (cp != 0) begin
      emit_code_point(cp);
    end else if (!lower_on) begin
      cp = upper_glyph(c);
      if (cp != 0) emit_code_point(cp);
      else emit_latin9(c);
    end else begin
      cp = lower_glyph(c);
      if (cp != 0) begin
        emit_code_point(cp);
      end else begin
        // shifted set swaps letter case
        if (c >= "A" && c <= "Z") c = c + 8'h20;
        else if (c >= "a" && c <= "z") c = c - 8'h20;
        emit_latin9(c);
      end
    end
  endtask

  task automatic predict_text(logic [7:0] c);
    int n;
    n = text_q.size();
    if (c <= 8'h1F || (c >= 8'h80 && c <= 8'h9F)) predict_control(c);
    else predict_printable(c);
    if (text_q.size() > n) text_q[text_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      glyph_on = 1'b0;
      iso_on = 1'b0;
      lower_on = 1'b0;
      fore = FORE_RESET;
      back = BACK_RESET;
      text_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) glyph_on = cfg_data_i;
      if (in_valid_i && in_ready_o) predict_text(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        checked_o++;
        if (text_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected beat byte=%02h last=%0b", $realtime,
                     out_byte_o, last_o);
        end else begin
          e = text_q.pop_front();
          if (e.data !== out_byte_o || e.last !== last_o) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: beat mismatch expected byte=%02h last=%0b, got %02h last=%0b",
                       $realtime, e.data, e.last, out_byte_o, last_o);
          end
        end
      end
    end
  end

endmodule

/* bench/petscii_to_utf8_terminal_unit_tb.sv */
// testbench top for the petscii to utf-8 terminal unit: stimulus, idling and verdict
`timescale 1ns / 100ps
module petscii_to_utf8_terminal_unit_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 62;
  localparam logic [7:0] SWAP_COLOURS = 8'h01;
  localparam logic [7:0] SHIFT_LOWER  = 8'h0E;
  localparam logic [7:0] TO_LATIN9    = 8'h0F;
  localparam logic [7:0] SHIFT_UPPER  = 8'h8E;
  localparam logic [7:0] TO_PETSCII   = 8'h8F;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_data_i = 1'b0;
  logic [7:0] in_byte_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  petscii_to_utf8_terminal_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_byte_i(in_byte_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_byte_o(out_byte_o), .last_o(last_o), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  petscii_to_utf8_terminal_unit_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_byte_i(in_byte_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_byte_o(out_byte_o), .last_o(last_o), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  // receiver: always ready, coin flip, or mostly stalled, in random stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= int'($urandom_range(0, 2));
      stall_left <= int'($urandom_range(10, 80));
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("FAIL petscii_to_utf8_terminal_unit");
        $finish;
      end
    end
  end

  // one beat; valid stays up inside a burst, gaps fall between bursts
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        if (gap == 0) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
      burst_left = int'($urandom_range(1, 20));
    end
    in_byte_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic drain_and_config(logic glyph);
    if (in_valid_i) in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // mode codes produce nothing and are never pushed into the command queue
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= glyph;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_byte();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return SHIFT_LOWER;
        1: return TO_LATIN9;
        2: return SHIFT_UPPER;
        3: return TO_PETSCII;
        default: return SWAP_COLOURS;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  logic [7:0] directed[] = '{8'h00, 8'hFF, 8'h02, 8'h41, 8'h7C, 8'h01, 8'h90, 8'h01,
                             8'h05, 8'h0A, 8'h0D, 8'h8D, 8'h92, 8'h93, 8'h14, 8'h1B,
                             8'h0E, 8'hFF, 8'h41, 8'h0F, 8'h7F, 8'hA4, 8'hE0, 8'h8E,
                             8'h8F};
  logic [7:0] line_ends[] = '{8'h0A, 8'h0D, 8'h8D};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain_and_config(1'b0);
    foreach (directed[i]) send_byte(directed[i]);
    drain_and_config(1'b1);
    foreach (line_ends[i]) send_byte(line_ends[i]);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_byte(random_byte());
      // hold off once until the output side has fully caught up
      if (i == RANDOM_PER_PHASE / 2) begin
        in_valid_i <= 1'b0;
        burst_left = 0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    drain_and_config(1'b0);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_byte(random_byte());
    drain_and_config(1'b1);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_byte(random_byte());
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d input bytes over both line-glyph settings, checked %0d output beats",
             sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS petscii_to_utf8_terminal_unit");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL petscii_to_utf8_terminal_unit");
    end
    $finish;
  end

endmodule
